// ----- rtl/core/tagged_chunk_hash_index_core_defines.svh -----
// Assertion macros used by the checker module tchi_checker.
`ifndef TAGGED_CHUNK_HASH_INDEX_CORE_DEFINES_SVH
`define TAGGED_CHUNK_HASH_INDEX_CORE_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock edge outside reset.
`define TCHI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCHI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tchi_pkg.sv -----
package tchi_pkg;
  localparam int NUM_CHUNKS        = 256;
  localparam int CHUNK_W           = $clog2(NUM_CHUNKS);
  localparam int SLOTS_PER_CHUNK   = 12;
  localparam int IDX_W             = 4;
  localparam int TAG_W             = 8;
  localparam int VAL_W             = 32;
  localparam int COUNT_W           = 12;
  localparam int MAX_MATCH_RESULTS = 63;
  localparam int MATCH_CNT_W       = 6;

  localparam logic [1:0] KIND_FIND = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;

  typedef logic [SLOTS_PER_CHUNK-1:0] mask_t;

  // One chunk as stored: fill count and the tags of all its slots.
  typedef struct packed {
    logic [IDX_W-1:0]                            fill;
    logic [SLOTS_PER_CHUNK-1:0][TAG_W-1:0]       tags;
  } row_t;

  typedef struct packed {
    logic                          row_rd;
    logic                          row_wr;
    logic [CHUNK_W-1:0]            row_addr;
    row_t                          row_wdata;
    logic                          val_rd;
    logic                          val_wr;
    logic [CHUNK_W+IDX_W-1:0]      val_addr;
    logic [VAL_W-1:0]              val_wdata;
  } store_req_t;
endpackage

// ----- rtl/core/tchi_store.sv -----
module tchi_store (
  input  logic                     clk,
  input  logic                     rst,
  input  tchi_pkg::store_req_t     req,
  output tchi_pkg::row_t           row,
  output logic [tchi_pkg::VAL_W-1:0] value
);
  import tchi_pkg::*;

  row_t                 row_mem [NUM_CHUNKS];
  logic [VAL_W-1:0]     val_mem [NUM_CHUNKS * (1 << IDX_W)];
  logic [NUM_CHUNKS-1:0] row_vld;
  row_t                 row_q;
  logic                 row_vld_q;

  // A chunk never written since reset reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (req.row_wr) begin
      row_vld[req.row_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.row_wr) begin
      row_mem[req.row_addr] <= req.row_wdata;
    end
    if (req.row_rd) begin
      row_q     <= row_mem[req.row_addr];
      row_vld_q <= row_vld[req.row_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.val_wr) begin
      val_mem[req.val_addr] <= req.val_wdata;
    end
    if (req.val_rd) begin
      value <= val_mem[req.val_addr];
    end
  end

  assign row = row_vld_q ? row_q : '0;
endmodule

// ----- rtl/core/tchi_match.sv -----
module tchi_match (
  input  tchi_pkg::row_t                 row,
  input  logic [tchi_pkg::TAG_W-1:0]     tag,
  output tchi_pkg::mask_t                mask
);
  import tchi_pkg::*;

  always_comb begin
    for (int i = 0; i < SLOTS_PER_CHUNK; i++) begin
      mask[i] = (row.tags[i] == tag);
    end
  end
endmodule

// ----- rtl/core/tagged_chunk_hash_index_core.sv -----
// Tagged chunk hash index: 256 chunks of 12 slots, each slot an 8-bit tag and
// a 32-bit value.
// Input channel s_*: one transaction is one operation, kind in s_tuser
// (find, add, set). Output channel m_*: one or more results per operation,
// m_tlast on the closing one, m_tuser high on a find match.
// Operations are handled one at a time; s_tready is low while one is busy.
// Add and set read the chunk row and write it back with the value; a refused
// set or an unknown kind goes straight to the closing result. A find walks
// chunks, each fetched as one row, and reads each matching value from the
// value memory port in turn, followed by the closing result.
// The walk over full chunks is bounded by the 256 chunks of the table.
// Reset clears the chunk valid bits, so every chunk reads empty, and the
// entry count; no clearing pass is needed and s_tready is high right after.
// When the receiver stalls, the result register holds and the sequencer
// waits on it; it resumes as soon as m_tready takes the pending result.
module tagged_chunk_hash_index_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // key_hash[63:0], slot[75:64], entry_value[107:76], zero pad
  input  logic [111:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // result_slot[11:0], result_value[43:12], no_slot[44], truncated[45],
  // total_entries[57:46], zero pad
  output logic [63:0]   m_tdata,
  // is_match[0]
  output logic          m_tuser,
  output logic          m_tlast
);
  import tchi_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_VAL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_SETRD = 3'd6;
  localparam logic [2:0] S_SETW  = 3'd7;

  logic [2:0]             state;
  logic [1:0]             kind;
  logic [TAG_W-1:0]       tag;
  logic [CHUNK_W-1:0]     pos;
  logic [CHUNK_W-1:0]     orig;
  logic [IDX_W-1:0]       set_idx;
  logic [VAL_W-1:0]       val;
  mask_t                  mask;
  row_t                   cur_row;
  logic [MATCH_CNT_W-1:0] n_match;
  logic                   trunc;
  logic [IDX_W-1:0]       hit_idx;
  logic [11:0]            fin_slot;
  logic                   fin_noslot;
  logic [COUNT_W-1:0]     count;

  store_req_t             req;
  row_t                   rd_row;
  logic [VAL_W-1:0]       rd_value;
  mask_t                  hit_mask;
  logic [IDX_W-1:0]       low_idx;
  logic                   out_free;
  logic                   emit;
  logic [TAG_W-1:0]       in_tag;
  logic [CHUNK_W-1:0]     pos_next;
  row_t                   new_row;

  tchi_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .row   (rd_row),
    .value (rd_value)
  );

  tchi_match u_match (
    .row  (rd_row),
    .tag  (tag),
    .mask (hit_mask)
  );

  assign out_free = !m_tvalid || m_tready;
  assign emit     = ((state == S_VAL) || (state == S_FIN)) && out_free;
  assign s_tready = (state == S_IDLE);
  assign in_tag   = (s_tdata[7:0] == '0) ? TAG_W'(1) : s_tdata[7:0];
  assign pos_next = pos + {tag[TAG_W-2:0], 1'b1};

  always_comb begin
    low_idx = '0;
    for (int i = SLOTS_PER_CHUNK - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  // Row to write back: add appends at the fill count, set writes its index.
  always_comb begin
    new_row = cur_row;
    if (state == S_SETW) begin
      new_row = rd_row;
      new_row.tags[set_idx] = tag;
      if (set_idx == rd_row.fill) begin
        new_row.fill = rd_row.fill + IDX_W'(1);
      end
    end else begin
      new_row.tags[cur_row.fill] = tag;
      new_row.fill = cur_row.fill + IDX_W'(1);
    end
  end

  always_comb begin
    req           = '0;
    req.row_addr  = pos;
    req.row_wdata = new_row;
    req.val_wdata = val;
    req.val_addr  = {pos, low_idx};
    unique case (state)
      S_READ, S_SETRD: begin
        req.row_rd = 1'b1;
      end
      S_SCAN: begin
        if (mask != '0) begin
          req.val_rd = (n_match < MATCH_CNT_W'(MAX_MATCH_RESULTS));
        end else if (cur_row.fill < IDX_W'(SLOTS_PER_CHUNK) && kind == KIND_ADD) begin
          req.row_wr   = 1'b1;
          req.val_wr   = 1'b1;
          req.val_addr = {pos, cur_row.fill};
        end
      end
      S_SETW: begin
        req.row_wr   = 1'b1;
        req.val_wr   = 1'b1;
        req.val_addr = {pos, set_idx};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind       <= s_tuser;
            tag        <= in_tag;
            pos        <= s_tdata[8 +: CHUNK_W];
            orig       <= s_tdata[8 +: CHUNK_W];
            val        <= s_tdata[76 +: VAL_W];
            set_idx    <= s_tdata[64 +: IDX_W];
            n_match    <= '0;
            trunc      <= 1'b0;
            fin_slot   <= s_tdata[75:64];
            fin_noslot <= 1'b0;
            if (s_tuser == KIND_FIND || s_tuser == KIND_ADD) begin
              state <= S_READ;
            end else if (s_tuser == KIND_SET) begin
              pos <= s_tdata[68 +: CHUNK_W];
              if (s_tdata[64 +: IDX_W] >= IDX_W'(SLOTS_PER_CHUNK)) begin
                fin_noslot <= 1'b1;
                state      <= S_FIN;
              end else begin
                state <= S_SETRD;
              end
            end else begin
              fin_slot   <= '0;
              fin_noslot <= 1'b1;
              state      <= S_FIN;
            end
          end
        end
        S_READ: begin
          state <= S_ROW;
        end
        S_ROW: begin
          cur_row <= rd_row;
          mask    <= (kind == KIND_FIND) ? hit_mask : '0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (mask != '0) begin
            if (n_match < MATCH_CNT_W'(MAX_MATCH_RESULTS)) begin
              hit_idx <= low_idx;
              state   <= S_VAL;
            end else begin
              // Every further match of the walk is dropped.
              trunc <= 1'b1;
              mask  <= '0;
            end
          end else if (cur_row.fill >= IDX_W'(SLOTS_PER_CHUNK)) begin
            if (pos_next == orig) begin
              fin_slot   <= '0;
              fin_noslot <= 1'b1;
              state      <= S_FIN;
            end else begin
              pos   <= pos_next;
              state <= S_READ;
            end
          end else begin
            fin_slot <= {pos, cur_row.fill};
            if (kind == KIND_ADD) begin
              count <= count + COUNT_W'(1);
            end
            state <= S_FIN;
          end
        end
        S_VAL: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b0;
            m_tdata  <= {6'd0, count, 1'b0, 1'b0, rd_value, pos, hit_idx};
            mask     <= mask & (mask - mask_t'(1));
            n_match  <= n_match + MATCH_CNT_W'(1);
            state    <= S_SCAN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            m_tdata  <= {6'd0, count, trunc, fin_noslot, {VAL_W{1'b0}}, fin_slot};
            state    <= S_IDLE;
          end
        end
        S_SETRD: begin
          state <= S_SETW;
        end
        S_SETW: begin
          if (set_idx == rd_row.fill) begin
            count <= count + COUNT_W'(1);
          end
          state <= S_FIN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- rtl/core/tchi_checker.sv -----
`include "tagged_chunk_hash_index_core_defines.svh"

module tchi_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [63:0]   m_tdata,
  input logic          m_tuser,
  input logic          m_tlast
);
  `TCHI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
  `TCHI_ASSERT_NOW(a_match_not_last, m_tvalid && m_tuser, !m_tlast, "match marked as closing result")
  `TCHI_ASSERT_NOW(a_match_flags, m_tvalid && m_tuser, m_tdata[45:44] == 2'b00, "match carries status flags")
  `TCHI_ASSERT_NOW(a_close_value, m_tvalid && m_tlast, m_tdata[43:12] == 32'd0, "closing result has a value")
  `TCHI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after an accepted transaction")
endmodule

bind tagged_chunk_hash_index_core tchi_checker u_tchi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
